### hdl/spca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SGM path cost aggregation package
// Shared types, configuration register indexes and constants.
// ----------------------------------------------------------------------------
package spca_pkg;

  localparam int unsigned CostW    = 8;
  localparam int unsigned SlotW    = 8;
  localparam int unsigned PenW     = 12;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CfgSmallPenalty   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLargePenalty   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDisparityCount = 2'd2;

  localparam logic [7:0]      SmallPenaltyRst   = 8'd10;
  localparam logic [PenW-1:0] LargePenaltyRst   = 12'd150;
  localparam logic [7:0]      DisparityCountRst = 8'd64;

  localparam logic [CostW-1:0] CostMax = 8'hFF;

  typedef struct packed {
    logic [CostW-1:0] match_cost;
    logic [7:0]       gray_value;
    logic             path_start;
  } spca_in_t;

  typedef struct packed {
    logic [CostW-1:0] aggregated_cost;
    logic [6:0]       disparity_slot;
    logic             pixel_done;
  } spca_out_t;

  typedef struct packed {
    logic [7:0]      small_penalty;
    logic [PenW-1:0] large_penalty;
    logic [7:0]      disparity_count;
  } spca_cfg_t;

  // one classified request on its way from front to back
  typedef struct packed {
    logic [CostW-1:0] cost;
    logic             start;
    logic [SlotW-1:0] slot;
    logic             done;
    logic [PenW-1:0]  pen;
  } spca_job_t;

endpackage
`default_nettype wire

### hdl/spca_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hdl/spca_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SGM request queue
// Two-entry queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module spca_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  spca_pkg::spca_job_t      data_i,
  output logic                     full_o,
  output logic                     valid_o,
  input  wire logic                pop_i,
  output spca_pkg::spca_job_t      data_o
);
  import spca_pkg::*;

  spca_job_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q != 2'd2)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0)
    else $error("queue pop while empty");

endmodule
`default_nettype wire

### hdl/spca_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SGM aggregation front
// Counts disparity slots, flags the last slot of a pixel and derives the
// pixel's jump penalty with a bit-serial divider on its first slot.
// ----------------------------------------------------------------------------
module spca_front #(
  parameter int unsigned MaxDisp = 128
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  spca_pkg::spca_cfg_t cfg_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  spca_pkg::spca_in_t  in_data_i,
  output logic                push_o,
  output spca_pkg::spca_job_t job_o,
  input  wire logic           full_i
);
  import spca_pkg::*;

  localparam int unsigned CW       = $clog2(MaxDisp);
  localparam int unsigned DivSteps = PenW;
  localparam int unsigned IterW    = $clog2(DivSteps);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StPush = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CW-1:0]    slot_q;
  logic [7:0]       last_gray_q;
  logic [PenW-1:0]  pen_q;
  logic [IterW-1:0] iter_q;
  spca_job_t        hold_q;
  logic [8:0]       divisor_q;
  logic [8:0]       rem_q;
  logic [PenW-1:0]  quo_q;

  logic            first, done, accept;
  logic [8:0]      cnt9, n9;
  logic [7:0]      diff;
  logic [9:0]      trial;
  logic            ge;
  logic [8:0]      rem_nx;
  logic [PenW-1:0] quo_nx, p1_ext, pen_nx;
  spca_job_t       job_now;

  always_comb begin
    first = (slot_q == '0);
    cnt9  = {1'b0, cfg_i.disparity_count};
    if (cnt9 == 9'd0) begin
      n9 = 9'd1;
    end else if (cnt9 > 9'(MaxDisp)) begin
      n9 = 9'(MaxDisp);
    end else begin
      n9 = cnt9;
    end
    done = ((9'(slot_q) + 9'd1) >= n9);
    diff = (in_data_i.gray_value > last_gray_q) ? in_data_i.gray_value - last_gray_q
                                                : last_gray_q - in_data_i.gray_value;

    in_stall_o = (state_q != StIdle) || (!first && full_i);
    accept     = in_valid_i && !in_stall_o;

    trial  = {rem_q, quo_q[PenW-1]};
    ge     = (trial >= {1'b0, divisor_q});
    rem_nx = ge ? 9'(trial - {1'b0, divisor_q}) : trial[8:0];
    quo_nx = {quo_q[PenW-2:0], ge};
    p1_ext = {{(PenW-8){1'b0}}, cfg_i.small_penalty};
    pen_nx = (quo_nx > p1_ext) ? quo_nx : p1_ext;

    job_now.cost  = in_data_i.match_cost;
    job_now.start = in_data_i.path_start;
    job_now.slot  = SlotW'(slot_q);
    job_now.done  = done;
    job_now.pen   = pen_q;

    push_o = ((state_q == StIdle) && accept && !first) || ((state_q == StPush) && !full_i);
    job_o  = (state_q == StPush) ? hold_q : job_now;
    job_o.pen = pen_q;

    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && first) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (iter_q == IterW'(DivSteps - 1)) begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (!full_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      slot_q      <= '0;
      last_gray_q <= 8'd0;
      pen_q       <= '0;
      iter_q      <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        slot_q <= done ? '0 : CW'(slot_q + 1'b1);
        if (done) begin
          last_gray_q <= in_data_i.gray_value;
        end
      end
      if (state_q == StDiv) begin
        iter_q <= IterW'(iter_q + 1'b1);
        if (iter_q == IterW'(DivSteps - 1)) begin
          pen_q <= pen_nx;
        end
      end else begin
        iter_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && first) begin
      hold_q    <= job_now;
      divisor_q <= {1'b0, diff} + 9'd1;
      rem_q     <= 9'd0;
      quo_q     <= cfg_i.large_penalty;
    end else if (state_q == StDiv) begin
      rem_q <= rem_nx;
      quo_q <= quo_nx;
    end
  end

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> iter_q <= IterW'(DivSteps - 1))
    else $error("divider ran past its last step");

endmodule
`default_nettype wire

### hdl/spca_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SGM aggregation back
// Applies the path recurrence, one request per cycle unless stalled, over a
// previous-row sliding window, writes the new row and registers the result.
// ----------------------------------------------------------------------------
module spca_back #(
  parameter int unsigned MaxDisp = 128
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  spca_pkg::spca_cfg_t cfg_i,
  input  wire logic           q_valid_i,
  input  spca_pkg::spca_job_t job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output spca_pkg::spca_out_t out_data_o
);
  import spca_pkg::*;

  localparam int unsigned CW       = $clog2(MaxDisp);
  localparam int unsigned RamDepth = 2 * (2 ** CW);

  logic             bank_q;
  logic [CostW-1:0] prev_min_q, run_min_q;
  logic [CostW-1:0] lo_q, mid_q;
  logic [CostW-1:0] head0_q [2];
  logic [CostW-1:0] head1_q [2];
  logic             out_valid_q;
  spca_out_t        out_q;

  logic [CW-1:0]    d;
  logic             first, rd_bank;
  logic [CostW-1:0] rdata, lo, mid, hi, hi_raw, agg, new_run;
  logic [8:0]       lo_p, hi_p;
  logic [12:0]      jump, best;

  always_comb begin
    d       = job_i.slot[CW-1:0];
    first   = (d == '0);
    rd_bank = ~bank_q;
    mid     = first ? head0_q[rd_bank] : mid_q;
    hi_raw  = first ? head1_q[rd_bank] : rdata;
    hi      = job_i.done ? CostMax : hi_raw;
    lo      = first ? CostMax : lo_q;

    lo_p = {1'b0, lo} + {1'b0, cfg_i.small_penalty};
    hi_p = {1'b0, hi} + {1'b0, cfg_i.small_penalty};
    jump = {5'b0, prev_min_q} + {1'b0, job_i.pen};

    best = {5'b0, mid};
    if ({4'b0, lo_p} < best) begin
      best = {4'b0, lo_p};
    end
    if ({4'b0, hi_p} < best) begin
      best = {4'b0, hi_p};
    end
    if (jump < best) begin
      best = jump;
    end

    agg     = job_i.start ? job_i.cost : job_i.cost + best[CostW-1:0] - prev_min_q;
    new_run = (agg < run_min_q) ? agg : run_min_q;
    pop_o   = q_valid_i && (!out_valid_q || !out_stall_i);
  end

  spca_ram #(
    .Width(CostW),
    .Depth(RamDepth)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (pop_o),
    .waddr_i({bank_q, d}),
    .wdata_i(agg),
    .re_i   (pop_o),
    .raddr_i({rd_bank, CW'(d + CW'(2))}),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q      <= 1'b0;
      prev_min_q  <= CostMax;
      run_min_q   <= CostMax;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        if (job_i.done) begin
          bank_q     <= ~bank_q;
          prev_min_q <= new_run;
          run_min_q  <= CostMax;
        end else begin
          run_min_q <= new_run;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      lo_q                  <= mid;
      mid_q                 <= hi_raw;
      out_q.aggregated_cost <= agg;
      out_q.disparity_slot  <= job_i.slot[6:0];
      out_q.pixel_done      <= job_i.done;
      if (d == '0) begin
        head0_q[bank_q] <= agg;
      end
      if (d == CW'(1)) begin
        head1_q[bank_q] <= agg;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_bank_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && job_i.done |=> bank_q != $past(bank_q))
    else $error("banks did not swap at end of pixel");

  a_min_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && job_i.done |=> run_min_q == CostMax && prev_min_q == $past(new_run))
    else $error("row minimum not handed over at end of pixel");

endmodule
`default_nettype wire

### hdl/sgm_path_cost_aggregation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SGM path cost aggregation
// Semi-global matching recurrence along one path, one disparity per request.
// ----------------------------------------------------------------------------
// Requests of a pixel arrive slot 0 upward; the block counts slots itself and
// returns one result per request. The first slot of every pixel waits in the
// front for the bit-serial divider that forms the jump penalty; the remaining
// slots then pass at one per cycle through the back, which reads one
// previous-row entry per cycle from the row RAM, while the queue is not full
// and the result side does not stall. An accepted request is stored in the
// queue and its result is registered in the back when the back pops it; slot 0
// first waits for the divider. The row RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module sgm_path_cost_aggregation #(
  parameter int unsigned MaxDisparities = 128
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [spca_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [spca_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  spca_pkg::spca_in_t                      in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output spca_pkg::spca_out_t                     out_data_o
);
  import spca_pkg::*;

  spca_cfg_t cfg_q;
  logic      push, full, q_valid, pop;
  spca_job_t push_job, pop_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.small_penalty   <= SmallPenaltyRst;
      cfg_q.large_penalty   <= LargePenaltyRst;
      cfg_q.disparity_count <= DisparityCountRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSmallPenalty:   cfg_q.small_penalty   <= cfg_wdata_i[7:0];
        CfgLargePenalty:   cfg_q.large_penalty   <= cfg_wdata_i[PenW-1:0];
        CfgDisparityCount: cfg_q.disparity_count <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  spca_front #(
    .MaxDisp(MaxDisparities)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .push_o    (push),
    .job_o     (push_job),
    .full_i    (full)
  );

  spca_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_job),
    .full_o (full),
    .valid_o(q_valid),
    .pop_i  (pop),
    .data_o (pop_job)
  );

  spca_back #(
    .MaxDisp(MaxDisparities)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .job_i      (pop_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

### tb/tb_sgm_path_cost_aggregation.sv
// ----------------------------------------------------------------------------
// SGM path cost aggregation testbench
// Streams per-disparity cost requests through the block in random bursts
// while the result side stalls on its own pattern. A behavioral copy of the
// path recurrence predicts each aggregated cost, slot and pixel end, and the
// results are checked in order. A short script covers register extremes,
// path starts, count changes and gray changes inside a pixel; random paths
// under changing register settings follow.
// ----------------------------------------------------------------------------
module tb_sgm_path_cost_aggregation;
  import spca_pkg::*;

  localparam int unsigned MaxDisp       = 128;
  localparam int unsigned TargetReqs    = 1100;
  localparam int unsigned WatchdogLimit = 3000;

  typedef enum logic {RowRequest, RowConfig} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  reg_index;
    logic [CfgDataW-1:0] reg_value;
    spca_in_t            req;
    bit                  known;
    spca_out_t           result;
  } script_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  spca_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  spca_out_t           out_data;

  logic [7:0]      small_pen    = SmallPenaltyRst;
  logic [PenW-1:0] large_pen    = LargePenaltyRst;
  logic [7:0]      disp_count   = DisparityCountRst;
  logic [7:0]      path_row [2][MaxDisp];
  bit              row_written [2][MaxDisp];
  bit              write_bank   = 1'b0;
  logic [7:0]      prev_row_min = CostMax;
  logic [7:0]      row_min      = CostMax;
  logic [7:0]      prev_gray    = '0;
  int unsigned     slot_count   = 0;
  logic [PenW-1:0] jump_pen     = '0;

  spca_out_t   agg_q [$];
  script_row_t script [$];
  int unsigned errors      = 0;
  int unsigned reqs_sent   = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_run   = 0;
  bit          steady      = 1'b0;

  sgm_path_cost_aggregation #(.MaxDisparities(MaxDisp)) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned eff_count();
    int unsigned n;
    n = disp_count;
    if (n < 1) n = 1;
    if (n > MaxDisp) n = MaxDisp;
    return n;
  endfunction

  function automatic spca_out_t aggregate_step(spca_in_t req);
    int unsigned n, d, diff, quot, best, lo, hi, jump, agg;
    bit rd, done;
    n  = eff_count();
    d  = slot_count;
    rd = ~write_bank;
    if (d == 0) begin
      diff = (req.gray_value > prev_gray) ? req.gray_value - prev_gray
                                          : prev_gray - req.gray_value;
      quot = large_pen / (diff + 1);
      jump_pen = PenW'((quot > small_pen) ? quot : small_pen);
    end
    if (req.path_start) begin
      agg = req.match_cost;
    end else begin
      best = path_row[rd][d];
      lo   = (d > 0) ? path_row[rd][d-1] : 255;
      hi   = (d + 1 < n) ? path_row[rd][d+1] : 255;
      jump = prev_row_min + jump_pen;
      if (lo + small_pen < best) best = lo + small_pen;
      if (hi + small_pen < best) best = hi + small_pen;
      if (jump < best) best = jump;
      agg = (req.match_cost + ((best - prev_row_min) & 'hFF)) & 'hFF;
    end
    path_row[write_bank][d]    = 8'(agg);
    row_written[write_bank][d] = 1'b1;
    if (agg < row_min) row_min = 8'(agg);
    done = (d + 1 >= n);
    if (done) begin
      write_bank   = ~write_bank;
      prev_row_min = row_min;
      row_min      = CostMax;
      prev_gray    = req.gray_value;
      slot_count   = 0;
    end else begin
      slot_count = d + 1;
    end
    return '{aggregated_cost: 8'(agg), disparity_slot: 7'(d), pixel_done: done};
  endfunction

  function automatic script_row_t cfg_row(logic [CfgIdxW-1:0] idx,
                                          logic [CfgDataW-1:0] value);
    return '{kind: RowConfig, reg_index: idx, reg_value: value, req: '0,
             known: 1'b0, result: '0};
  endfunction

  function automatic script_row_t req_row(logic [7:0] cost, logic [7:0] gray,
                                          logic start, bit known = 1'b0,
                                          logic [7:0] agg = '0,
                                          logic [6:0] slot = '0,
                                          logic done = 1'b0);
    return '{kind: RowRequest, reg_index: '0, reg_value: '0,
             req: '{match_cost: cost, gray_value: gray, path_start: start},
             known: known,
             result: '{aggregated_cost: agg, disparity_slot: slot, pixel_done: done}};
  endfunction

  function automatic void add_row(script_row_t row);
    script.insert(script.size(), row);
  endfunction

  // Force a path start where the previous row has not written the slot or one of its neighbors.
  task automatic send_request(input spca_in_t req, input bit known,
                              input spca_out_t result);
    int unsigned n, d;
    bit rd;
    spca_out_t predicted;
    n  = eff_count();
    d  = slot_count;
    rd = ~write_bank;
    if (!req.path_start && (!row_written[rd][d] || (d > 0 && !row_written[rd][d-1]) ||
        (d + 1 < n && !row_written[rd][d+1])))
      req.path_start = 1'b1;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = aggregate_step(req);
    agg_q.insert(agg_q.size(), known ? result : predicted);
    reqs_sent++;
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] value);
    in_valid <= 1'b0;
    while (agg_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgSmallPenalty:   small_pen  = value[7:0];
      CfgLargePenalty:   large_pen  = value[PenW-1:0];
      CfgDisparityCount: disp_count = value[7:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : stall_pattern
    if (stall_run > 0) begin
      stall_run--;
    end else if (!out_stall && $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_run = $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
      stall_run = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 80 : 15);
    end
  end

  always @(posedge clk) begin : result_check
    spca_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (agg_q.size() == 0) begin
        $display("%0t: result with none expected: expected none, actual %p",
                 $time, out_data);
        errors++;
      end else begin
        want = agg_q.pop_front();
        if (out_data.aggregated_cost !== want.aggregated_cost) begin
          $display("%0t: aggregated_cost expected %0d actual %0d", $time,
                   want.aggregated_cost, out_data.aggregated_cost);
          errors++;
        end
        if (out_data.disparity_slot !== want.disparity_slot) begin
          $display("%0t: disparity_slot expected %0d actual %0d", $time,
                   want.disparity_slot, out_data.disparity_slot);
          errors++;
        end
        if (out_data.pixel_done !== want.pixel_done) begin
          $display("%0t: pixel_done expected %0d actual %0d", $time,
                   want.pixel_done, out_data.pixel_done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned phase_left;
    bit cut_mid, pixel_start;
    logic [7:0] pixel_gray;
    logic [CfgDataW-1:0] value;
    spca_in_t req;
    pixel_gray  = '0;
    pixel_start = 1'b1;

    add_row(cfg_row(CfgDisparityCount, 12'd1));
    add_row(req_row(8'd0, 8'd0, 1'b1, 1'b1, 8'd0, 7'd0, 1'b1));
    add_row(req_row(8'd255, 8'd255, 1'b1, 1'b1, 8'd255, 7'd0, 1'b1));
    add_row(req_row(8'd128, 8'd0, 1'b0));
    add_row(cfg_row(CfgDisparityCount, 12'd0));
    add_row(req_row(8'd255, 8'd255, 1'b0));
    add_row(cfg_row(CfgDisparityCount, 12'd3));
    add_row(cfg_row(CfgSmallPenalty, 12'd255));
    add_row(cfg_row(CfgLargePenalty, 12'd4095));
    add_row(req_row(8'd0, 8'd0, 1'b1, 1'b1, 8'd0, 7'd0, 1'b0));
    add_row(req_row(8'd128, 8'd0, 1'b1, 1'b1, 8'd128, 7'd1, 1'b0));
    add_row(req_row(8'd255, 8'd0, 1'b1, 1'b1, 8'd255, 7'd2, 1'b1));
    add_row(req_row(8'd255, 8'd255, 1'b0));
    add_row(req_row(8'd1, 8'd255, 1'b0));
    add_row(req_row(8'd0, 8'd255, 1'b0));
    add_row(req_row(8'd0, 8'd255, 1'b0));
    add_row(req_row(8'd0, 8'd255, 1'b0));
    add_row(req_row(8'd255, 8'd255, 1'b0));
    add_row(cfg_row(CfgSmallPenalty, 12'd0));
    add_row(cfg_row(CfgLargePenalty, 12'd0));
    add_row(req_row(8'd10, 8'd128, 1'b0));
    add_row(req_row(8'd20, 8'd7, 1'b0));
    add_row(req_row(8'd30, 8'd128, 1'b1, 1'b1, 8'd30, 7'd2, 1'b1));
    add_row(req_row(8'd5, 8'd128, 1'b0));
    add_row(req_row(8'd6, 8'd128, 1'b0));
    add_row(cfg_row(CfgDisparityCount, 12'd2));
    add_row(req_row(8'd7, 8'd128, 1'b0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == RowConfig) begin
        write_reg(script[i].reg_index, script[i].reg_value);
      end else begin
        send_request(script[i].req, script[i].known, script[i].result);
        pace_sender();
      end
    end

    while (reqs_sent < TargetReqs) begin
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       value = '0;
        1:       value = 12'd255;
        2, 3:    value = CfgDataW'($urandom_range(0, 40));
        default: value = CfgDataW'($urandom_range(0, 255));
      endcase
      write_reg(CfgSmallPenalty, value);
      case ($urandom_range(0, 4))
        0:       value = '0;
        1:       value = 12'd4095;
        2:       value = CfgDataW'($urandom_range(0, 300));
        default: value = CfgDataW'($urandom_range(0, 4095));
      endcase
      write_reg(CfgLargePenalty, value);
      case ($urandom_range(0, 15))
        0:       value = '0;
        1:       value = 12'd1;
        2:       value = 12'd128;
        3:       value = 12'd255;
        4, 5:    value = CfgDataW'($urandom_range(9, 32));
        default: value = CfgDataW'($urandom_range(2, 8));
      endcase
      write_reg(CfgDisparityCount, value);

      phase_left = (eff_count() >= 64) ? eff_count() * $urandom_range(1, 3)
                                       : $urandom_range(20, 80);
      if (phase_left > TargetReqs - reqs_sent) phase_left = TargetReqs - reqs_sent;
      cut_mid = ($urandom_range(0, 3) == 0);
      while (phase_left > 0 || (slot_count != 0 && !cut_mid)) begin
        if (slot_count == 0) begin
          pixel_start = ($urandom_range(0, 9) == 0);
          case ($urandom_range(0, 3))
            0:       ;
            1:       pixel_gray = 8'($urandom_range(0, 255));
            default: pixel_gray = 8'(pixel_gray + $urandom_range(0, 6) - 3);
          endcase
        end
        req.match_cost = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 31))
                                                     : 8'($urandom_range(0, 255));
        req.gray_value = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255))
                                                      : pixel_gray;
        req.path_start = ($urandom_range(0, 39) == 0) ? ~pixel_start : pixel_start;
        send_request(req, 1'b0, '0);
        pace_sender();
        if (phase_left > 0) phase_left--;
      end
    end

    in_valid <= 1'b0;
    while (agg_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### sgm_path_cost_aggregation.f
hdl/spca_pkg.sv
hdl/spca_ram.sv
hdl/spca_queue.sv
hdl/spca_front.sv
hdl/spca_back.sv
hdl/sgm_path_cost_aggregation.sv
tb/tb_sgm_path_cost_aggregation.sv
